// ===== src/sliding_window_rate_meter_macros.svh =====
// assertion macros for the sliding window rate meter
`ifndef SLIDING_WINDOW_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_RATE_METER_MACROS_SVH

// clocked assertion, held off while reset is active
`define SWRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SWRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/swrm_pkg.sv =====
// shared types and constants of the sliding window rate meter
package swrm_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned LEN_W   = 19;
  localparam int unsigned WIN_W   = 32;
  localparam int unsigned PKTS_W  = 9;
  localparam int unsigned WBITS_W = 27;
  localparam int unsigned DRATE_W = 47;
  localparam int unsigned PRATE_W = 28;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd1000000;
  // register index taken from paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0] arrival_time;
    logic [LEN_W-1:0]  packet_length_bits;
  } swrm_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OVF,
    ST_APPEND,
    ST_WAIT,
    ST_EVICT,
    ST_MUL,
    ST_DIV,
    ST_RES
  } swrm_state_e;

endpackage

// ===== src/swrm_if.sv =====
// channel interfaces for packets in and rate reports out
interface swrm_in_if import swrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [LEN_W-1:0]  packet_length_bits;

  modport source (output valid, arrival_time, packet_length_bits, input ready);
  modport sink   (input valid, arrival_time, packet_length_bits, output ready);
endinterface

interface swrm_out_if import swrm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PKTS_W-1:0]  window_packets;
  logic [WBITS_W-1:0] window_bits;
  logic [DRATE_W-1:0] data_rate;
  logic [PRATE_W-1:0] packet_rate;
  logic               overflow;

  modport source (output valid, window_packets, window_bits, data_rate, packet_rate,
                  overflow, input ready);
  modport sink   (input valid, window_packets, window_bits, data_rate, packet_rate,
                  overflow, output ready);
endinterface

// ===== src/sliding_window_rate_meter.sv =====
// top level of the sliding window rate meter
// Each accepted transaction is one packet (arrival time in ticks, length in
// bits) and yields one report: packets and bits inside the window plus the
// data and packet rates, sum * TICKS_PER_SECOND / window_ticks truncated and
// saturated. A two entry queue in front takes packets while the back end
// works; the back end handles one packet at a time: an overflow step when a
// full fifo forces out its oldest entry, append, wait, evictions (one entry
// per cycle through the fifo head read port while entries expire), a
// multiply step, a bit-serial divide over the N bits of the rate product
// (48 with default parameters) and a result step. The fifo memory needs no
// clearing pass after reset. window_ticks sits at byte address 0 of the APB
// port; the user must write it only while idle, the block does not enforce it.
module sliding_window_rate_meter import swrm_pkg::*; #(
  parameter int unsigned DEPTH            = 256,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  swrm_in_if.sink           in_i,
  swrm_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // window register, cleared to the default window on reset
  logic [WIN_W-1:0] window_q, window_d;
  logic             cfg_wr;

  // queue handoff between front and back
  logic       pop_valid, pop_ready;
  swrm_item_t pop_item;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  // only register 0 exists; only paddr[2] is decoded, addresses with it set are ignored
  always_comb begin
    window_d = window_q;
    if (cfg_wr && paddr[2] == REG_WINDOW) window_d = pwdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else begin
      window_q <= window_d;
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW) ? window_q : '0;

  // front: packet intake
  swrm_front u_front (
    .clk_i, .rst_ni, .in_i,
    .pop_valid_o(pop_valid), .pop_item_o(pop_item), .pop_ready_i(pop_ready)
  );

  // back: fifo, eviction and rate computation
  swrm_back #(.DEPTH(DEPTH), .TICKS_PER_SECOND(TICKS_PER_SECOND)) u_back (
    .clk_i, .rst_ni, .window_i(window_q),
    .pop_valid_i(pop_valid), .pop_item_i(pop_item), .pop_ready_o(pop_ready),
    .out_o
  );

endmodule

// ===== src/swrm_front.sv =====
// front end: accepts packets into a two entry queue
module swrm_front import swrm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  swrm_in_if.sink     in_i,
  output logic        pop_valid_o,
  output swrm_item_t  pop_item_o,
  input  logic        pop_ready_i
);

  swrm_item_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;

  assign in_i.ready  = (fill_q != 2'd2);
  assign push        = in_i.valid & in_i.ready;
  assign pop_valid_o = (fill_q != 2'd0);
  assign pop         = pop_valid_o & pop_ready_i;
  assign pop_item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{arrival_time: in_i.arrival_time,
                            packet_length_bits: in_i.packet_length_bits};
    end
  end

endmodule

// ===== src/swrm_div.sv =====
// restoring divider, one quotient bit per cycle
module swrm_div import swrm_pkg::*; #(
  parameter int unsigned N = 57
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [N-1:0]     dividend_i,
  input  logic [WIN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [N-1:0]     quot_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic [N-1:0]     quo_q, quo_d;
  logic [WIN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [WIN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[N-1]};
  assign fits   = (rem_sh >= {1'b0, divisor_i});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? WIN_W'(rem_sh - {1'b0, divisor_i}) : rem_sh[WIN_W-1:0];
      quo_d = {quo_q[N-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(N - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/swrm_back.sv =====
// back end: packet fifo, eviction sequencer and rate division
module swrm_back import swrm_pkg::*; #(
  parameter int unsigned DEPTH            = 256,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIN_W-1:0] window_i,
  input  logic             pop_valid_i,
  input  swrm_item_t       pop_item_i,
  output logic             pop_ready_o,
  swrm_out_if.source       out_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > PKTS_W) ? CNT_W : PKTS_W;
  localparam int unsigned BSUM  = LEN_W + CNT_W;
  localparam int unsigned BW    = (BSUM > WBITS_W) ? BSUM : WBITS_W;
  localparam int unsigned TW    = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PSUM  = BW + TW;
  localparam int unsigned DPW   = (PSUM > DRATE_W + 1) ? PSUM : DRATE_W + 1;
  localparam logic [TW-1:0] TPS = TW'(TICKS_PER_SECOND);

  logic [TIME_W-1:0] mem_time [DEPTH];
  logic [LEN_W-1:0]  mem_len  [DEPTH];

  swrm_state_e       state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;
  logic [BW-1:0]     bits_q, bits_d;
  logic [TIME_W-1:0] rd_time_q;
  logic [LEN_W-1:0]  rd_len_q;
  swrm_item_t        cur_q;
  logic              ovf_q, ovf_d;
  logic [DPW-1:0]    dprod_q, pprod_q;

  logic              out_vld_q, out_vld_d;
  logic [PKTS_W-1:0]  o_pkts_q;
  logic [WBITS_W-1:0] o_bits_q;
  logic [DRATE_W-1:0] o_drate_q;
  logic [PRATE_W-1:0] o_prate_q;
  logic               o_ovf_q;

  logic [WIN_W-1:0]  divisor;
  logic              div_start, dq_done, pq_done;
  logic [DPW-1:0]    dquot, pquot;
  logic [AW:0]       tail_sum;
  logic [AW-1:0]     tail, head_inc;
  logic              expired, full, wr_en, take_item, load_out, drop;

  assign divisor   = (window_i == '0) ? WIN_W'(1) : window_i;
  assign full      = (count_q == CW'(DEPTH));
  assign expired   = ({1'b0, rd_time_q} + (TIME_W+1)'(window_i)) <
                     {1'b0, cur_q.arrival_time};
  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum  = {1'b0, head_q} + (AW+1)'(count_q);
  assign tail      = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                 : tail_sum[AW-1:0];
  assign load_out  = !out_vld_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (pop_valid_i) state_d = full ? ST_OVF : ST_APPEND;
      ST_OVF:    state_d = ST_APPEND;
      ST_APPEND: state_d = ST_WAIT;
      ST_WAIT:   state_d = ST_EVICT;
      ST_EVICT:  if (!(count_q != '0 && expired)) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV;
      ST_DIV:    if (dq_done) state_d = ST_RES;
      ST_RES:    if (load_out) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take_item = 1'b0;
    wr_en     = 1'b0;
    drop      = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE:   take_item = pop_valid_i;
      ST_OVF:    drop      = 1'b1;
      ST_APPEND: wr_en     = 1'b1;
      ST_EVICT:  drop      = (count_q != '0) && expired;
      ST_MUL:    div_start = 1'b1;
      default:   ;
    endcase
  end

  assign pop_ready_o = (state_q == ST_IDLE);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    bits_d  = bits_q;
    ovf_d   = ovf_q;
    if (take_item) ovf_d = 1'b0;
    if (state_q == ST_OVF) ovf_d = !expired;
    if (drop) begin
      head_d  = head_inc;
      count_d = count_q - 1'b1;
      bits_d  = bits_q - BW'(rd_len_q);
    end
    if (wr_en) begin
      count_d = count_q + 1'b1;
      bits_d  = bits_q + BW'(cur_q.packet_length_bits);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      bits_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      bits_q    <= bits_d;
      out_vld_q <= out_vld_d;
    end
  end

  // fifo memory, head read always follows the next head
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[tail] <= cur_q.arrival_time;
      mem_len[tail]  <= cur_q.packet_length_bits;
    end
    rd_time_q <= mem_time[head_d];
    rd_len_q  <= mem_len[head_d];
  end

  always_ff @(posedge clk_i) begin
    ovf_q <= ovf_d;
    if (take_item) cur_q <= pop_item_i;
    if (state_q == ST_EVICT) begin
      dprod_q <= DPW'(bits_q * TPS);
      pprod_q <= DPW'(count_q * TPS);
    end
  end

  swrm_div #(.N(DPW)) u_div_data (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(dprod_q),
    .divisor_i(divisor), .done_o(dq_done), .quot_o(dquot)
  );

  swrm_div #(.N(DPW)) u_div_pkt (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(pprod_q),
    .divisor_i(divisor), .done_o(pq_done), .quot_o(pquot)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) out_vld_d = 1'b0;
    if (state_q == ST_RES && load_out) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RES && load_out) begin
      o_pkts_q  <= count_q[PKTS_W-1:0];
      o_bits_q  <= bits_q[WBITS_W-1:0];
      o_drate_q <= (|dquot[DPW-1:DRATE_W]) ? '1 : dquot[DRATE_W-1:0];
      o_prate_q <= (|pquot[DPW-1:PRATE_W]) ? '1 : pquot[PRATE_W-1:0];
      o_ovf_q   <= ovf_q & (pq_done | 1'b1);
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.window_packets = o_pkts_q;
  assign out_o.window_bits    = o_bits_q;
  assign out_o.data_rate      = o_drate_q;
  assign out_o.packet_rate    = o_prate_q;
  assign out_o.overflow       = o_ovf_q;

endmodule

// ===== src/swrm_checker.sv =====
// port level checker for the sliding window rate meter, with its bind
`include "sliding_window_rate_meter_macros.svh"

module swrm_checker import swrm_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PKTS_W-1:0]  window_packets,
  input logic [WBITS_W-1:0] window_bits
);

  `SWRM_ASSERT(a_pkts_bound, out_valid |-> (window_packets <= PKTS_W'(DEPTH)), "count above depth")
  `SWRM_ASSERT(a_empty_no_bits, (out_valid && window_packets == '0) |-> (window_bits == '0), "bits in empty window")
  `SWRM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(window_bits)), "report dropped while stalled")
  `SWRM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid, "report during reset")

endmodule

bind sliding_window_rate_meter swrm_checker #(.DEPTH(DEPTH)) u_swrm_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .window_packets(out_o.window_packets),
  .window_bits(out_o.window_bits)
);
